FILE: sv/chpc_pkg.sv
`timescale 1ns / 1ps
package chpc_pkg;

  localparam int COORD_FRAC_DEF = 16;
  localparam int TAPER_FRAC     = 16;
  localparam int ROUGH_LOW      = 100;
  localparam int ROUGH_HIGH     = 100000;

  localparam int COORD_W    = 32;
  localparam int PERP_W     = 81;
  localparam int MAG_W      = 88;
  localparam int RAD_W      = 89;
  localparam int ROOT_W     = 45;
  localparam int PROD_W     = 77;
  localparam int QUO_W      = 40;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_AXIS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TAPER = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_APEXX = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_APEXY = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_APEXZ = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SENSE = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_TOL   = 3'd6;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;

  typedef enum logic [1:0] {
    POS_INSIDE  = 2'd0,
    POS_SURFACE = 2'd1,
    POS_OUTSIDE = 2'd2
  } pos_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
  } in_t;

  typedef struct packed {
    logic [1:0] position;
    logic       used_fine_distance;
  } out_t;

  typedef struct packed {
    logic               rough;
    logic [1:0]         rpos;
    logic [COORD_W-1:0] ax;
  } sq_side_t;

  typedef struct packed {
    logic       rough;
    logic [1:0] rpos;
    logic       dneg;
    logic       pz;
  } dv_side_t;

endpackage

FILE: sv/chpc_sqrt.sv
`timescale 1ns / 1ps
module chpc_sqrt import chpc_pkg::*; #(
  parameter int RW = RAD_W,
  parameter int RB = ROOT_W,
  parameter int NL = 3,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [RW-1:0] rad [NL],
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [RB-1:0] root [NL],
  output logic [SW-1:0] out_side
);

  logic [RW-1:0] rem_r  [RB][NL];
  logic [RB-1:0] rt_r   [RB][NL];
  logic [SW-1:0] side_r [RB];
  logic          vld_r  [RB];
  logic [RW-1:0] rem_c  [RB][NL];
  logic [RB-1:0] rt_c   [RB][NL];
  logic [SW-1:0] side_c [RB];
  logic          vld_c  [RB];

  for (genvar k = 0; k < RB; k++) begin : g_stage
    localparam int B = RB - 1 - k;
    if (k == 0) begin : g_first
      assign vld_c[k]  = in_valid;
      assign side_c[k] = in_side;
      for (genvar l = 0; l < NL; l++) begin : g_lane
        assign rem_c[k][l] = rad[l];
        assign rt_c[k][l]  = '0;
      end
    end else begin : g_next
      assign vld_c[k]  = vld_r[k-1];
      assign side_c[k] = side_r[k-1];
      for (genvar l = 0; l < NL; l++) begin : g_lane
        assign rem_c[k][l] = rem_r[k-1][l];
        assign rt_c[k][l]  = rt_r[k-1][l];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_c[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_r[k] <= side_c[k];
      end
    end

    for (genvar l = 0; l < NL; l++) begin : g_bit
      logic [RW+1:0] trial;
      logic          take;
      always_comb begin
        trial = ({{(RW+2-RB){1'b0}}, rt_c[k][l]} << (B + 1)) + ((RW+2)'(1) << (2 * B));
        take  = trial <= {2'b00, rem_c[k][l]};
      end
      always_ff @(posedge clk) begin
        if (en) begin
          rt_r[k][l] <= take ? (rt_c[k][l] | (RB'(1) << B)) : rt_c[k][l];
        end
      end
      if (k < RB - 1) begin : g_rem
        always_ff @(posedge clk) begin
          if (en) begin
            rem_r[k][l] <= take ? rem_c[k][l] - trial[RW-1:0] : rem_c[k][l];
          end
        end
      end
    end
  end

  assign out_valid = vld_r[RB-1];
  assign out_side  = side_r[RB-1];
  for (genvar l = 0; l < NL; l++) begin : g_out
    assign root[l] = rt_r[RB-1][l];
  end

endmodule

FILE: sv/chpc_div.sv
`timescale 1ns / 1ps
module chpc_div import chpc_pkg::*; #(
  parameter int NW = PROD_W,
  parameter int DW = ROOT_W,
  parameter int QB = QUO_W,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [QB-1:0] quo,
  output logic [SW-1:0] out_side
);

  logic [DW-1:0] rem_r  [QB];
  logic [QB-1:0] q_r    [QB];
  logic [QB-1:0] nlo_r  [QB];
  logic [DW-1:0] d_r    [QB];
  logic [SW-1:0] side_r [QB];
  logic          vld_r  [QB];
  logic [DW-1:0] rem_c  [QB];
  logic [QB-1:0] q_c    [QB];
  logic [QB-1:0] nlo_c  [QB];
  logic [DW-1:0] d_c    [QB];
  logic [SW-1:0] side_c [QB];
  logic          vld_c  [QB];

  for (genvar k = 0; k < QB; k++) begin : g_stage
    logic [DW:0] rem2;
    logic        take;

    if (k == 0) begin : g_first
      assign rem_c[k]  = DW'(num[NW-1:QB]);
      assign q_c[k]    = '0;
      assign nlo_c[k]  = num[QB-1:0];
      assign d_c[k]    = den;
      assign side_c[k] = in_side;
      assign vld_c[k]  = in_valid;
    end else begin : g_next
      assign rem_c[k]  = rem_r[k-1];
      assign q_c[k]    = q_r[k-1];
      assign nlo_c[k]  = nlo_r[k-1];
      assign d_c[k]    = d_r[k-1];
      assign side_c[k] = side_r[k-1];
      assign vld_c[k]  = vld_r[k-1];
    end

    always_comb begin
      rem2 = {rem_c[k], nlo_c[k][QB-1]};
      take = rem2 >= {1'b0, d_c[k]};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_c[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= take ? DW'(rem2 - {1'b0, d_c[k]}) : rem2[DW-1:0];
        q_r[k]    <= {q_c[k][QB-2:0], take};
        nlo_r[k]  <= nlo_c[k] << 1;
        d_r[k]    <= d_c[k];
        side_r[k] <= side_c[k];
      end
    end
  end

  assign out_valid = vld_r[QB-1];
  assign quo       = q_r[QB-1];
  assign out_side  = side_r[QB-1];

endmodule

FILE: sv/cone_halfspace_point_classify.sv
`timescale 1ns / 1ps
// Classifies one point per cycle against a half-space bounded by an axis-aligned cone.
// The block is a fully pipelined datapath of 95 register stages: six stages form the offsets,
// squares and quadric value, 45 stages take three square roots side by side one result bit
// each, three stages form the distance numerator, 40 stages divide one quotient bit each, and
// one output register holds the result. An item is accepted every cycle unless the output
// register holds a valid result under out_stall, which freezes the whole pipeline. The user
// must write configuration only while no item is in flight; the block does not enforce it.
module cone_halfspace_point_classify import chpc_pkg::*; #(
  parameter int COORD_FRAC_BITS = COORD_FRAC_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_t                   in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_t                  out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int SHIFT = COORD_FRAC_BITS + TAPER_FRAC;

  logic [1:0]                axis_r;
  logic [23:0]               taper_r;
  logic signed [COORD_W-1:0] apex_x_r, apex_y_r, apex_z_r;
  logic                      sneg_r;
  logic [15:0]               tol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axis_r   <= 2'd2;
      taper_r  <= 24'd65536;
      apex_x_r <= '0;
      apex_y_r <= '0;
      apex_z_r <= '0;
      sneg_r   <= 1'b0;
      tol_r    <= 16'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_AXIS:  axis_r   <= cfg_data[1:0];
        CFG_TAPER: taper_r  <= cfg_data[23:0];
        CFG_APEXX: apex_x_r <= cfg_data;
        CFG_APEXY: apex_y_r <= cfg_data;
        CFG_APEXZ: apex_z_r <= cfg_data;
        CFG_SENSE: sneg_r   <= cfg_data[0];
        CFG_TOL:   tol_r    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  logic [22:0]      band;
  logic [32:0]      hi_base;
  logic [MAG_W-1:0] lo_thr, hi_thr;
  assign band    = 23'(ROUGH_LOW) * 23'(tol_r);
  assign hi_base = 33'(ROUGH_HIGH) * 33'(tol_r);
  assign lo_thr  = MAG_W'(band) << SHIFT;
  assign hi_thr  = MAG_W'(hi_base) << SHIFT;

  logic en;
  logic out_valid_r;
  out_t out_data_r;
  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  function automatic logic [COORD_W-1:0] absd(input logic [COORD_W-1:0] p,
                                              input logic [COORD_W-1:0] a);
    logic [COORD_W:0] d;
    d = {p[COORD_W-1], p} - {a[COORD_W-1], a};
    if (d[COORD_W]) d = ~d + 1'b1;
    return d[COORD_W-1:0];
  endfunction

  // offsets and axis selection
  logic [COORD_W-1:0] dx, dy, dz;
  logic               s1_v;
  logic [COORD_W-1:0] s1_ax, s1_p1, s1_p2;
  assign dx = absd(in_data.point_x, apex_x_r);
  assign dy = absd(in_data.point_y, apex_y_r);
  assign dz = absd(in_data.point_z, apex_z_r);

  always_ff @(posedge clk) begin
    if (en) begin
      case (axis_r)
        AXIS_X: begin
          s1_ax <= dx; s1_p1 <= dy; s1_p2 <= dz;
        end
        AXIS_Y: begin
          s1_ax <= dy; s1_p1 <= dx; s1_p2 <= dz;
        end
        default: begin
          s1_ax <= dz; s1_p1 <= dx; s1_p2 <= dy;
        end
      endcase
    end
  end

  // squares
  logic        s2_v;
  logic [63:0] s2_ax2, s2_pp1, s2_pp2;
  logic [31:0] s2_ax;
  always_ff @(posedge clk) begin
    if (en) begin
      s2_ax2 <= 64'(s1_ax) * 64'(s1_ax);
      s2_pp1 <= 64'(s1_p1) * 64'(s1_p1);
      s2_pp2 <= 64'(s1_p2) * 64'(s1_p2);
      s2_ax  <= s1_ax;
    end
  end

  // perpendicular sum and taper partial products
  logic              s3_v;
  logic [PERP_W-1:0] s3_perp;
  logic [55:0]       s3_axl, s3_axh;
  logic [63:0]       s3_ax2;
  logic [31:0]       s3_ax;
  always_ff @(posedge clk) begin
    if (en) begin
      s3_perp <= (PERP_W'(s2_pp1) + PERP_W'(s2_pp2)) << TAPER_FRAC;
      s3_axl  <= 56'(taper_r) * 56'(s2_ax2[31:0]);
      s3_axh  <= 56'(taper_r) * 56'(s2_ax2[63:32]);
      s3_ax2  <= s2_ax2;
      s3_ax   <= s2_ax;
    end
  end

  logic              s4_v;
  logic [MAG_W-1:0]  s4_axq;
  logic [PERP_W-1:0] s4_perp;
  logic [63:0]       s4_ax2;
  logic [31:0]       s4_ax;
  always_ff @(posedge clk) begin
    if (en) begin
      s4_axq  <= MAG_W'(s3_axl) + (MAG_W'(s3_axh) << 32);
      s4_perp <= s3_perp;
      s4_ax2  <= s3_ax2;
      s4_ax   <= s3_ax;
    end
  end

  // quadric magnitude and sign
  logic              s5_v;
  logic [MAG_W-1:0]  s5_mag, s5_axq;
  logic              s5_neg;
  logic [RAD_W-1:0]  s5_prad;
  logic [PERP_W-1:0] s5_perp;
  logic [31:0]       s5_ax;
  logic              perp_ge;
  assign perp_ge = MAG_W'(s4_perp) >= s4_axq;
  always_ff @(posedge clk) begin
    if (en) begin
      s5_mag  <= perp_ge ? MAG_W'(s4_perp) - s4_axq : s4_axq - MAG_W'(s4_perp);
      s5_neg  <= !perp_ge ^ sneg_r;
      s5_prad <= RAD_W'(s4_axq) + (RAD_W'(s4_ax2) << TAPER_FRAC);
      s5_axq  <= s4_axq;
      s5_perp <= s4_perp;
      s5_ax   <= s4_ax;
    end
  end

  // rough decision
  logic              s6_v;
  sq_side_t          s6_side;
  logic [PERP_W-1:0] s6_perp;
  logic [MAG_W-1:0]  s6_axq;
  logic [RAD_W-1:0]  s6_prad;
  always_ff @(posedge clk) begin
    if (en) begin
      s6_side.rough <= (s5_mag > hi_thr) || (s5_mag < lo_thr);
      s6_side.rpos  <= (s5_mag > lo_thr) ? (s5_neg ? POS_OUTSIDE : POS_INSIDE) : POS_SURFACE;
      s6_side.ax    <= s5_ax;
      s6_perp       <= s5_perp;
      s6_axq        <= s5_axq;
      s6_prad       <= s5_prad;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
      s4_v <= 1'b0;
      s5_v <= 1'b0;
      s6_v <= 1'b0;
    end else if (en) begin
      s1_v <= in_valid;
      s2_v <= s1_v;
      s3_v <= s2_v;
      s4_v <= s3_v;
      s5_v <= s4_v;
      s6_v <= s5_v;
    end
  end

  // three roots
  logic [RAD_W-1:0]  rad  [3];
  logic [ROOT_W-1:0] root [3];
  logic              sq_v;
  sq_side_t          sq_side;
  assign rad[0] = RAD_W'(s6_perp);
  assign rad[1] = RAD_W'(s6_axq);
  assign rad[2] = s6_prad;

  chpc_sqrt #(
    .RW(RAD_W), .RB(ROOT_W), .NL(3), .SW($bits(sq_side_t))
  ) u_sqrt (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(s6_v), .rad(rad), .in_side(s6_side),
    .out_valid(sq_v), .root(root), .out_side(sq_side)
  );

  // distance numerator
  logic              sa_v, sb_v, sc_v;
  logic [ROOT_W-1:0] sa_nmag, sa_p, sb_p, sc_p;
  logic [31:0]       sa_ax;
  dv_side_t          sa_side, sb_side, sc_side;
  logic [60:0]       sb_lo, sb_hi;
  logic [PROD_W-1:0] sc_n;
  always_ff @(posedge clk) begin
    if (en) begin
      sa_nmag       <= (root[0] < root[1]) ? root[1] - root[0] : root[0] - root[1];
      sa_side.dneg  <= (root[0] < root[1]) ^ sneg_r;
      sa_side.pz    <= root[2] == '0;
      sa_side.rough <= sq_side.rough;
      sa_side.rpos  <= sq_side.rpos;
      sa_p          <= root[2];
      sa_ax         <= sq_side.ax;
      sb_lo         <= 61'(sa_nmag) * 61'(sa_ax[15:0]);
      sb_hi         <= 61'(sa_nmag) * 61'(sa_ax[31:16]);
      sb_p          <= sa_p;
      sb_side       <= sa_side;
      sc_n          <= PROD_W'(sb_lo) + (PROD_W'(sb_hi) << 16);
      sc_p          <= sb_p;
      sc_side       <= sb_side;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sa_v <= 1'b0;
      sb_v <= 1'b0;
      sc_v <= 1'b0;
    end else if (en) begin
      sa_v <= sq_v;
      sb_v <= sa_v;
      sc_v <= sb_v;
    end
  end

  logic             dv_v;
  logic [QUO_W-1:0] dv_q;
  dv_side_t         dv_side;

  chpc_div #(
    .NW(PROD_W), .DW(ROOT_W), .QB(QUO_W), .SW($bits(dv_side_t))
  ) u_div (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(sc_v), .num(sc_n), .den(sc_p), .in_side(sc_side),
    .out_valid(dv_v), .quo(dv_q), .out_side(dv_side)
  );

  // final decision
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r.used_fine_distance <= !dv_side.rough;
      if (dv_side.rough) begin
        out_data_r.position <= dv_side.rpos;
      end else if (dv_side.pz || dv_q <= QUO_W'(band)) begin
        out_data_r.position <= POS_SURFACE;
      end else begin
        out_data_r.position <= dv_side.dneg ? POS_OUTSIDE : POS_INSIDE;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r && $stable(out_data_r))
    else $error("result changed while stalled");

  a_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_data_r.position != 2'd3)
    else $error("invalid position code");

  a_apex: assert property (@(posedge clk) disable iff (!rst_n)
    en && dv_v && !dv_side.rough && dv_side.pz |=>
      out_data_r.position == POS_SURFACE && out_data_r.used_fine_distance)
    else $error("zero divisor not classed as surface");

endmodule
